// File: sv/twvs_pkg.sv
// Shared types and constants of the three-voice wavetable synthesizer.
`default_nettype none

package twvs_pkg;

  localparam int TABLE_DEPTH_DEF = 16384;
  localparam int VOICES_DEF      = 3;

  localparam int MODE_W   = 2;
  localparam int VOICE_W  = 2;
  localparam int STEP_W   = 14;
  localparam int RATE_W   = 8;
  localparam int VOL_W    = 15;
  localparam int ADDR_W   = 14;
  localparam int SAMPLE_W = 16;
  localparam int REG_W    = 16;
  localparam int DAC_W    = 12;
  localparam int CFG_IDX_W = 2;
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 16;

  localparam int MUL_B_W = 17;
  localparam int PROD_W  = 32;
  localparam int TERM_W  = 22;

  localparam int UNITY_SHIFT = 10;
  localparam int UNITY_ROUND = 1023;
  localparam int GAIN_SHIFT  = 16;
  localparam int DAC_MID     = 2048;
  localparam int DAC_MAX     = 4095;

  localparam logic [REG_W-1:0] DECAY_PERIOD_RST = 16'd16;
  localparam logic [REG_W-1:0] CUTOFF_LEVEL_RST = 16'd0;
  localparam logic [REG_W-1:0] VOLUME_SCALE_RST = 16'd7282;

  typedef enum logic [MODE_W-1:0] {
    MODE_SAMPLE = 2'd0,
    MODE_DECAY  = 2'd1,
    MODE_STRIKE = 2'd2,
    MODE_WRITE  = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DECAY_PERIOD = 2'd0,
    CFG_CUTOFF_LEVEL = 2'd1,
    CFG_VOLUME_SCALE = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [2:0]                 pad;
    logic signed [SAMPLE_W-1:0] table_value;
    logic [ADDR_W-1:0]          table_addr;
    logic [VOL_W-1:0]           strike_volume;
    logic [RATE_W-1:0]          fall_step;
    logic [STEP_W-1:0]          phase_step;
    logic [VOICE_W-1:0]         voice;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       pad;
    logic             busy_res;
    logic [DAC_W-1:0] dac_value;
  } out_item_t;

endpackage

`default_nettype wire

// File: sv/twvs_mul.sv
// Shared signed multiplier with a registered product.
`default_nettype none

module twvs_mul #(
  parameter int AW = 23,
  parameter int BW = twvs_pkg::MUL_B_W
) (
  input  wire logic                 clk_i,
  input  wire logic signed [AW-1:0] a_i,
  input  wire logic signed [BW-1:0] b_i,
  output logic signed [AW+BW-1:0]   p_o
);

  logic signed [AW+BW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= (AW+BW)'(a_i) * (AW+BW)'(b_i);
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

// File: sv/three_voice_wavetable_synth.sv
// Top level of the three-voice wavetable synthesizer: sequencer, table, voice state.
//
//   channel   dir  handshake                        payload
//   s_axis    in   s_axis_tvalid / s_axis_tready    tdata: item fields, tuser: mode
//   m_axis    out  m_axis_tvalid / m_axis_tready    tdata: dac_value, busy_res
//   cfg       in   cfg_valid_i / cfg_ready_o        cfg_index_i, cfg_data_i
//
// A sample tick while playing steps each voice in turn through phase add, wrap, multiply
// and accumulate, repeating the wrap step while the phase is past the table end; the shared
// multiplier serves every voice in turn, then the master gain, before the scaled sum is
// clamped into the DAC register. Every other item goes straight to the done state.
// Reset clears voice state, counters and the DAC register (mid-scale); the wave table
// holds garbage until written. The block takes no item until its result is loaded
// into the output register; a stalled result holds there.
`default_nettype none

module three_voice_wavetable_synth #(
  parameter int TABLE_DEPTH = twvs_pkg::TABLE_DEPTH_DEF,
  parameter int VOICES      = twvs_pkg::VOICES_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // voice, phase_step, fall_step, strike_volume, table_addr, table_value, zero fill
  input  wire logic [twvs_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // mode
  input  wire logic [twvs_pkg::MODE_W-1:0]      s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // dac_value, busy_res, zero fill
  output logic [twvs_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [twvs_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [twvs_pkg::REG_W-1:0]       cfg_data_i
);

  localparam int PW    = $clog2(TABLE_DEPTH);
  localparam int SUMW  = ((PW > twvs_pkg::STEP_W) ? PW : twvs_pkg::STEP_W) + 1;
  localparam int VW    = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int ACCW  = twvs_pkg::TERM_W + $clog2(VOICES);
  localparam int MW    = ACCW + twvs_pkg::MUL_B_W;
  localparam int QW    = ACCW + 1;
  localparam int CMPW  = 17;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_PHASE = 8'b0000_0010,
    ST_WRAP  = 8'b0000_0100,
    ST_MUL   = 8'b0000_1000,
    ST_ACC   = 8'b0001_0000,
    ST_GAIN  = 8'b0010_0000,
    ST_SCALE = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } state_e;

  state_e state_q;

  twvs_pkg::in_item_t  in_item;
  twvs_pkg::out_item_t out_q;
  twvs_pkg::mode_e     mode;

  logic [twvs_pkg::REG_W-1:0]        period_q;
  logic signed [twvs_pkg::REG_W-1:0] cutoff_q;
  logic [twvs_pkg::REG_W-1:0]        scale_q;

  logic [PW-1:0]                        phase_q [VOICES];
  logic [twvs_pkg::STEP_W-1:0]          step_q  [VOICES];
  logic signed [twvs_pkg::SAMPLE_W-1:0] amp_q   [VOICES];
  logic [twvs_pkg::RATE_W-1:0]          rate_q  [VOICES];
  logic [twvs_pkg::REG_W-1:0]           count_q;
  logic                                 playing_q;
  logic [twvs_pkg::DAC_W-1:0]           dac_q;
  logic [twvs_pkg::DAC_W-1:0]           shown_q;

  logic [VW-1:0]           voice_q;
  logic [SUMW-1:0]         ph_q;
  logic signed [ACCW-1:0]  acc_q;

  logic signed [twvs_pkg::SAMPLE_W-1:0] mem [TABLE_DEPTH];
  logic signed [twvs_pkg::SAMPLE_W-1:0] rd_q;
  logic                                 we;
  logic [PW-1:0]                        waddr;

  logic signed [ACCW-1:0]                 mul_a;
  logic signed [twvs_pkg::MUL_B_W-1:0]    mul_b;
  logic signed [MW-1:0]                   prod;

  logic signed [twvs_pkg::SAMPLE_W-1:0] amp_dec [VOICES];
  logic [twvs_pkg::REG_W-1:0]           count_dec;
  logic                                 drop_now;
  logic                                 all_zero;

  logic signed [twvs_pkg::PROD_W-1:0] prod_lo;
  logic signed [twvs_pkg::PROD_W-1:0] term;
  logic signed [ACCW-1:0]             acc_d;
  logic signed [QW-1:0]               q;
  logic signed [QW-1:0]               dac_sum;
  logic [twvs_pkg::DAC_W-1:0]         dac_d;
  logic [VW-1:0]                      vidx;
  logic                               in_acc;
  logic                               out_load;

  assign in_item = twvs_pkg::in_item_t'(s_axis_tdata);
  assign mode    = twvs_pkg::mode_e'(s_axis_tuser);
  assign vidx    = VW'(in_item.voice);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign out_load      = (state_q == ST_DONE) && (!m_axis_tvalid || m_axis_tready);

  // Wave table
  assign we    = in_acc && (mode == twvs_pkg::MODE_WRITE) &&
                 (CMPW'(in_item.table_addr) < CMPW'(TABLE_DEPTH));
  assign waddr = PW'(in_item.table_addr);

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= in_item.table_value;
    end
    rd_q <= mem[ph_q[PW-1:0]];
  end

  // Shared multiplier
  always_comb begin
    if (state_q == ST_GAIN) begin
      mul_a = acc_q;
      mul_b = $signed({1'b0, scale_q});
    end else begin
      mul_a = ACCW'(rd_q);
      mul_b = twvs_pkg::MUL_B_W'(amp_q[voice_q]);
    end
  end

  twvs_mul #(
    .AW(ACCW),
    .BW(twvs_pkg::MUL_B_W)
  ) u_mul (
    .clk_i(clk_i),
    .a_i  (mul_a),
    .b_i  (mul_b),
    .p_o  (prod)
  );

  // Voice term truncated toward zero, accumulate
  always_comb begin
    prod_lo = prod[twvs_pkg::PROD_W-1:0];
    if (prod_lo[twvs_pkg::PROD_W-1]) begin
      term = (prod_lo + twvs_pkg::PROD_W'(twvs_pkg::UNITY_ROUND)) >>> twvs_pkg::UNITY_SHIFT;
    end else begin
      term = prod_lo >>> twvs_pkg::UNITY_SHIFT;
    end
    acc_d = acc_q + ACCW'(term);
  end

  // Gain, offset and clamp
  always_comb begin
    q       = QW'(prod >>> twvs_pkg::GAIN_SHIFT);
    dac_sum = q + QW'(twvs_pkg::DAC_MID);
    if (dac_sum[QW-1]) begin
      dac_d = '0;
    end else if (dac_sum > QW'(twvs_pkg::DAC_MAX)) begin
      dac_d = twvs_pkg::DAC_W'(twvs_pkg::DAC_MAX);
    end else begin
      dac_d = dac_sum[twvs_pkg::DAC_W-1:0];
    end
  end

  // Decay step over all voices
  always_comb begin
    count_dec = (count_q != '0) ? count_q - 1'b1 : count_q;
    drop_now  = (count_dec == '0);
    all_zero  = 1'b1;
    for (int i = 0; i < VOICES; i++) begin
      amp_dec[i] = amp_q[i];
      if (drop_now) begin
        if (amp_q[i] != '0) begin
          amp_dec[i] = amp_q[i] - $signed({8'b0, rate_q[i]});
        end
        if (amp_dec[i] <= cutoff_q) begin
          amp_dec[i] = '0;
        end
      end
      if (amp_dec[i] != '0) begin
        all_zero = 1'b0;
      end
    end
    if (drop_now) begin
      count_dec = period_q;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= twvs_pkg::DECAY_PERIOD_RST;
      cutoff_q <= twvs_pkg::CUTOFF_LEVEL_RST;
      scale_q  <= twvs_pkg::VOLUME_SCALE_RST;
    end else if (cfg_valid_i) begin
      case (twvs_pkg::cfg_idx_e'(cfg_index_i))
        twvs_pkg::CFG_DECAY_PERIOD: period_q <= cfg_data_i;
        twvs_pkg::CFG_CUTOFF_LEVEL: cutoff_q <= cfg_data_i;
        twvs_pkg::CFG_VOLUME_SCALE: scale_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer and voice state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      playing_q <= 1'b0;
      dac_q     <= twvs_pkg::DAC_W'(twvs_pkg::DAC_MID);
      shown_q   <= '0;
      voice_q   <= '0;
      ph_q      <= '0;
      acc_q     <= '0;
      for (int i = 0; i < VOICES; i++) begin
        phase_q[i] <= '0;
        step_q[i]  <= '0;
        amp_q[i]   <= '0;
        rate_q[i]  <= '0;
      end
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            shown_q <= dac_q;
            state_q <= ST_DONE;
            case (mode)
              twvs_pkg::MODE_SAMPLE: begin
                if (playing_q) begin
                  voice_q <= '0;
                  acc_q   <= '0;
                  state_q <= ST_PHASE;
                end
              end
              twvs_pkg::MODE_DECAY: begin
                count_q <= count_dec;
                for (int i = 0; i < VOICES; i++) begin
                  amp_q[i] <= amp_dec[i];
                end
                if (all_zero) begin
                  playing_q <= 1'b0;
                end
              end
              twvs_pkg::MODE_STRIKE: begin
                playing_q <= 1'b1;
                if (32'(in_item.voice) < VOICES) begin
                  step_q[vidx]  <= in_item.phase_step;
                  phase_q[vidx] <= '0;
                  rate_q[vidx]  <= in_item.fall_step;
                  amp_q[vidx]   <= $signed({1'b0, in_item.strike_volume});
                end
              end
              default: ;
            endcase
          end
        end
        ST_PHASE: begin
          ph_q    <= SUMW'(phase_q[voice_q]) + SUMW'(step_q[voice_q]);
          state_q <= ST_WRAP;
        end
        ST_WRAP: begin
          if (ph_q >= SUMW'(TABLE_DEPTH)) begin
            ph_q <= ph_q - SUMW'(TABLE_DEPTH);
          end else begin
            phase_q[voice_q] <= ph_q[PW-1:0];
            state_q          <= ST_MUL;
          end
        end
        ST_MUL: begin
          state_q <= ST_ACC;
        end
        ST_ACC: begin
          acc_q <= acc_d;
          if (voice_q == VW'(VOICES - 1)) begin
            state_q <= ST_GAIN;
          end else begin
            voice_q <= voice_q + 1'b1;
            state_q <= ST_PHASE;
          end
        end
        ST_GAIN: begin
          state_q <= ST_SCALE;
        end
        ST_SCALE: begin
          dac_q   <= dac_d;
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.pad       <= '0;
      out_q.busy_res  <= playing_q;
      out_q.dac_value <= shown_q;
    end
  end

  assign m_axis_tdata = out_q;

endmodule

`default_nettype wire

// File: tb/tb_three_voice_wavetable_synth.sv
`timescale 1ns / 100ps
// Self-checking testbench for the three-voice wavetable synthesizer.
module tb_three_voice_wavetable_synth;

  localparam int VOICE_CNT        = twvs_pkg::VOICES_DEF;
  localparam int DEPTH            = twvs_pkg::TABLE_DEPTH_DEF;
  // voice steps stay on multiples of the stride, so only these slots are read
  localparam int PHASE_STRIDE     = 256;
  localparam int PHASE_SLOTS      = DEPTH / PHASE_STRIDE;
  localparam int CYCLE_LIMIT      = 1_500_000;
  localparam int SETTLE_CYCLES    = 32;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int MAX_REPORTS      = 40;

  typedef struct {
    twvs_pkg::mode_e    mode;
    twvs_pkg::in_item_t data;
  } synth_item_t;

  logic                            clk_i         = 1'b0;
  logic                            rst_ni        = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [twvs_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [twvs_pkg::MODE_W-1:0]     s_axis_tuser  = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [twvs_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                            cfg_valid_i   = 1'b0;
  logic                            cfg_ready_o;
  logic [twvs_pkg::CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [twvs_pkg::REG_W-1:0]      cfg_data_i    = '0;

  three_voice_wavetable_synth dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // predicted synthesizer state
  logic signed [twvs_pkg::SAMPLE_W-1:0] wave_mem    [DEPTH];
  logic [twvs_pkg::STEP_W-1:0]          voice_phase [VOICE_CNT];
  logic [twvs_pkg::STEP_W-1:0]          voice_inc   [VOICE_CNT];
  logic signed [twvs_pkg::REG_W-1:0]    voice_amp   [VOICE_CNT];
  logic [twvs_pkg::RATE_W-1:0]          voice_fall  [VOICE_CNT];
  logic [twvs_pkg::REG_W-1:0]           decay_left;
  logic                                 note_on;
  logic [twvs_pkg::DAC_W-1:0]           dac_hold;
  logic [twvs_pkg::REG_W-1:0]           period_reg;
  logic signed [twvs_pkg::REG_W-1:0]    cutoff_reg;
  logic [twvs_pkg::REG_W-1:0]           gain_reg;

  synth_item_t         stim_q[$];
  twvs_pkg::out_item_t dac_expect_q[$];
  synth_item_t         next_item;
  twvs_pkg::out_item_t got_out;
  twvs_pkg::out_item_t want_out;

  bit idle_on      = 1'b0;
  int send_gap     = 0;
  int stall_left   = 0;
  int hold_left    = 0;
  bit hold_done    = 1'b0;
  int long_hold_at = 32'h7fff_ffff;
  int items_queued = 0;
  int items_taken  = 0;
  int results_seen = 0;
  int fail_cnt     = 0;
  int cycle_cnt    = 0;
  int write_cnt    = 0;
  int played_cnt   = 0;
  int clip_cnt     = 0;
  int fade_cnt     = 0;
  int settings_cnt = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic twvs_pkg::out_item_t synth_next(twvs_pkg::mode_e mode,
                                                     twvs_pkg::in_item_t d);
    twvs_pkg::out_item_t res;
    int                  mix;
    longint              level;
    logic                any_amp;
    res = '0;
    res.dac_value = dac_hold;
    case (mode)
      twvs_pkg::MODE_SAMPLE: begin
        if (note_on) begin
          mix = 0;
          for (int v = 0; v < VOICE_CNT; v++) begin
            voice_phase[v] = twvs_pkg::STEP_W'((int'(voice_phase[v]) + int'(voice_inc[v]))
                                               % DEPTH);
            mix += (int'(wave_mem[voice_phase[v]]) * int'(voice_amp[v])) / 1024;
          end
          level = (longint'(mix) * longint'(gain_reg)) >>> twvs_pkg::GAIN_SHIFT;
          level += twvs_pkg::DAC_MID;
          if (level < 0 || level > twvs_pkg::DAC_MAX) clip_cnt++;
          if (level < 0) level = 0;
          if (level > twvs_pkg::DAC_MAX) level = twvs_pkg::DAC_MAX;
          dac_hold = twvs_pkg::DAC_W'(level);
          played_cnt++;
        end
      end
      twvs_pkg::MODE_DECAY: begin
        if (decay_left != 0) decay_left--;
        if (decay_left == 0) begin
          for (int v = 0; v < VOICE_CNT; v++) begin
            if (voice_amp[v] != 0)
              voice_amp[v] = voice_amp[v] - twvs_pkg::REG_W'(voice_fall[v]);
            if (voice_amp[v] <= cutoff_reg) voice_amp[v] = '0;
          end
          decay_left = period_reg;
        end
        any_amp = 1'b0;
        for (int v = 0; v < VOICE_CNT; v++)
          if (voice_amp[v] != 0) any_amp = 1'b1;
        if (!any_amp && note_on) fade_cnt++;
        if (!any_amp) note_on = 1'b0;
      end
      twvs_pkg::MODE_STRIKE: begin
        note_on = 1'b1;
        if (int'(d.voice) < VOICE_CNT) begin
          voice_inc[d.voice]   = d.phase_step;
          voice_phase[d.voice] = '0;
          voice_fall[d.voice]  = d.fall_step;
          voice_amp[d.voice]   = twvs_pkg::REG_W'(d.strike_volume);
        end
      end
      default: begin
        if (int'(d.table_addr) < DEPTH) wave_mem[d.table_addr] = d.table_value;
        write_cnt++;
      end
    endcase
    res.busy_res = note_on;
    return res;
  endfunction

  function automatic twvs_pkg::in_item_t pack_fields(int voice, int inc, int fall, int vol,
                                                     int addr, int value);
    twvs_pkg::in_item_t d;
    d = '0;
    d.voice         = twvs_pkg::VOICE_W'(voice);
    d.phase_step    = twvs_pkg::STEP_W'(inc);
    d.fall_step     = twvs_pkg::RATE_W'(fall);
    d.strike_volume = twvs_pkg::VOL_W'(vol);
    d.table_addr    = twvs_pkg::ADDR_W'(addr);
    d.table_value   = twvs_pkg::SAMPLE_W'(value);
    return d;
  endfunction

  function automatic synth_item_t random_item();
    synth_item_t it;
    int          pick;
    it.data = twvs_pkg::in_item_t'(twvs_pkg::IN_DATA_W'({$urandom, $urandom, $urandom}));
    it.data.pad = '0;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      it.mode = twvs_pkg::MODE_SAMPLE;
    end else if (pick < 75) begin
      it.mode = twvs_pkg::MODE_DECAY;
    end else if (pick < 90) begin
      it.mode = twvs_pkg::MODE_STRIKE;
      if ($urandom_range(0, 9) == 0) it.data.voice = twvs_pkg::VOICE_W'(VOICE_CNT);
      else it.data.voice = twvs_pkg::VOICE_W'($urandom_range(0, VOICE_CNT - 1));
      it.data.phase_step = twvs_pkg::STEP_W'($urandom_range(0, PHASE_SLOTS - 1)
                                             * PHASE_STRIDE);
      if ($urandom_range(0, 3) != 0)
        it.data.strike_volume = twvs_pkg::VOL_W'($urandom_range(0, 2047));
      if ($urandom_range(0, 1) != 0)
        it.data.fall_step = twvs_pkg::RATE_W'($urandom_range(0, 31));
    end else begin
      it.mode = twvs_pkg::MODE_WRITE;
    end
    return it;
  endfunction

  task automatic add_item(twvs_pkg::mode_e mode, twvs_pkg::in_item_t d);
    synth_item_t it;
    it.mode = mode;
    it.data = d;
    stim_q.push_back(it);
    items_queued++;
  endtask

  task automatic add_random(int count);
    repeat (count) begin
      stim_q.push_back(random_item());
      items_queued++;
    end
  endtask

  task automatic wait_drained();
    while (items_taken != items_queued || dac_expect_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_regs(logic [twvs_pkg::REG_W-1:0] period,
                          logic [twvs_pkg::REG_W-1:0] cutoff,
                          logic [twvs_pkg::REG_W-1:0] gain);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= twvs_pkg::CFG_DECAY_PERIOD;
    cfg_data_i  <= period;
    do @(posedge clk_i); while (!cfg_ready_o);
    period_reg = period;
    cfg_index_i <= twvs_pkg::CFG_CUTOFF_LEVEL;
    cfg_data_i  <= cutoff;
    do @(posedge clk_i); while (!cfg_ready_o);
    cutoff_reg = cutoff;
    cfg_index_i <= twvs_pkg::CFG_VOLUME_SCALE;
    cfg_data_i  <= gain;
    do @(posedge clk_i); while (!cfg_ready_o);
    gain_reg = gain;
    cfg_valid_i <= 1'b0;
    settings_cnt++;
  endtask

  task automatic report_mismatch(string msg);
    if (fail_cnt < MAX_REPORTS) $display("MISMATCH at result %0d: %s", results_seen, msg);
    fail_cnt++;
  endtask

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      send_gap      <= 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) begin
        dac_expect_q.push_back(synth_next(twvs_pkg::mode_e'(s_axis_tuser),
                                          twvs_pkg::in_item_t'(s_axis_tdata)));
        items_taken++;
      end
      if (send_gap != 0) begin
        s_axis_tvalid <= 1'b0;
        send_gap      <= send_gap - 1;
      end else if (stim_q.size() != 0 && idle_on && $urandom_range(0, 7) == 0) begin
        s_axis_tvalid <= 1'b0;
        send_gap      <= $urandom_range(0, 4);
      end else if (stim_q.size() != 0) begin
        next_item = stim_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= next_item.mode;
        s_axis_tdata  <= next_item.data;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver backpressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left    <= 0;
      hold_left     <= 0;
      hold_done     <= 1'b0;
    end else if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (!hold_done && items_taken >= long_hold_at) begin
      m_axis_tready <= 1'b0;
      hold_left     <= LONG_HOLD_CYCLES;
      hold_done     <= 1'b1;
    end else if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= $urandom_range(0, 4);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // result scoreboard
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_out = twvs_pkg::out_item_t'(m_axis_tdata);
      if (dac_expect_q.size() == 0) begin
        report_mismatch($sformatf("unexpected transaction dac %0d busy %0d",
                                  got_out.dac_value, got_out.busy_res));
      end else begin
        want_out = dac_expect_q.pop_front();
        if (got_out.dac_value !== want_out.dac_value)
          report_mismatch($sformatf("dac_value %0d, expected %0d",
                                    got_out.dac_value, want_out.dac_value));
        if (got_out.busy_res !== want_out.busy_res)
          report_mismatch($sformatf("busy_res %0b, expected %0b",
                                    got_out.busy_res, want_out.busy_res));
      end
      results_seen++;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results pending", cycle_cnt, dac_expect_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int value;
    for (int v = 0; v < VOICE_CNT; v++) begin
      voice_phase[v] = '0;
      voice_inc[v]   = '0;
      voice_amp[v]   = '0;
      voice_fall[v]  = '0;
    end
    decay_left = '0;
    note_on    = 1'b0;
    dac_hold   = twvs_pkg::DAC_W'(twvs_pkg::DAC_MID);
    period_reg = twvs_pkg::DECAY_PERIOD_RST;
    cutoff_reg = twvs_pkg::CUTOFF_LEVEL_RST;
    gain_reg   = twvs_pkg::VOLUME_SCALE_RST;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fill every slot a voice phase can reach before any voice reads it
    for (int a = 0; a < DEPTH; a += PHASE_STRIDE) begin
      if (a == 0) value = 32767;
      else if (a == DEPTH - PHASE_STRIDE) value = -32768;
      else value = int'($signed(twvs_pkg::SAMPLE_W'($urandom)));
      add_item(twvs_pkg::MODE_WRITE, pack_fields(0, 0, 0, 0, a, value));
    end
    wait_drained();

    // directed items at reset register values
    idle_on = 1'b1;
    add_item(twvs_pkg::MODE_SAMPLE, pack_fields(0, 0, 0, 0, 0, 0));
    add_item(twvs_pkg::MODE_STRIKE, pack_fields(0, 0, 0, 32767, 0, 0));
    add_item(twvs_pkg::MODE_SAMPLE, pack_fields(0, 0, 0, 0, 0, 0));
    add_item(twvs_pkg::MODE_SAMPLE, pack_fields(0, 0, 0, 0, 0, 0));
    add_item(twvs_pkg::MODE_STRIKE, pack_fields(1, 16128, 255, 200, 0, 0));
    add_item(twvs_pkg::MODE_STRIKE, pack_fields(2, 256, 1, 0, 0, 0));
    add_item(twvs_pkg::MODE_SAMPLE, pack_fields(0, 0, 0, 0, 0, 0));
    add_item(twvs_pkg::MODE_DECAY,  pack_fields(0, 0, 0, 0, 0, 0));
    add_item(twvs_pkg::MODE_STRIKE, pack_fields(VOICE_CNT, 5, 9, 500, 0, 0));
    add_item(twvs_pkg::MODE_WRITE,  pack_fields(0, 0, 0, 0, 8191, 12345));
    add_item(twvs_pkg::MODE_SAMPLE, pack_fields(0, 0, 0, 0, 0, 0));
    add_item(twvs_pkg::MODE_STRIKE, pack_fields(0, 16128, 255, 32767, 0, 0));
    add_item(twvs_pkg::MODE_SAMPLE, pack_fields(0, 0, 0, 0, 0, 0));
    add_item(twvs_pkg::MODE_SAMPLE, pack_fields(0, 0, 0, 0, 0, 0));
    add_item(twvs_pkg::MODE_STRIKE, pack_fields(0, 8192, 0, 0, 0, 0));
    add_item(twvs_pkg::MODE_SAMPLE, pack_fields(0, 0, 0, 0, 0, 0));
    add_item(twvs_pkg::MODE_DECAY,  pack_fields(0, 0, 0, 0, 0, 0));
    add_item(twvs_pkg::MODE_SAMPLE, pack_fields(0, 0, 0, 0, 0, 0));
    add_item(twvs_pkg::MODE_DECAY,  pack_fields(0, 0, 0, 0, 0, 0));
    add_item(twvs_pkg::MODE_WRITE,  pack_fields(0, 0, 0, 0, 0, 32767));
    wait_drained();

    // drop on every decay tick, full gain
    set_regs(16'd0, 16'd0, 16'hffff);
    add_random(150);
    wait_drained();

    // slowest decay, lowest cutoff, no idling
    idle_on = 1'b0;
    set_regs(16'hffff, 16'h8000, twvs_pkg::VOLUME_SCALE_RST);
    add_random(150);
    wait_drained();

    // highest cutoff, zero gain
    idle_on = 1'b1;
    set_regs(16'd3, 16'h7fff, 16'd0);
    add_random(100);
    wait_drained();

    // receiver holds off long enough to back up the input
    set_regs(twvs_pkg::REG_W'($urandom_range(0, 24)),
             twvs_pkg::REG_W'($urandom_range(0, 600) - 300),
             twvs_pkg::REG_W'($urandom));
    long_hold_at = items_taken + 60;
    add_random(300);
    wait_drained();

    // final stretch without idling
    idle_on = 1'b0;
    set_regs(twvs_pkg::REG_W'($urandom_range(1, 40)),
             twvs_pkg::REG_W'($urandom_range(0, 200) - 100),
             twvs_pkg::REG_W'($urandom));
    add_random(200);
    wait_drained();

    $display("Covered %0d items: %0d table writes, %0d played samples (%0d clipped)",
             items_taken, write_cnt, played_cnt, clip_cnt);
    $display("%0d results checked over %0d register settings, %0d notes faded out",
             results_seen, settings_cnt, fade_cnt);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", fail_cnt);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/twvs_pkg.sv
sv/twvs_mul.sv
sv/three_voice_wavetable_synth.sv
tb/tb_three_voice_wavetable_synth.sv
